>>> hw/rtl/rtmp_chunk_serializer_macros.svh
// assertion macros for the chunk serializer checker
`ifndef RTMP_CHUNK_SERIALIZER_MACROS_SVH
`define RTMP_CHUNK_SERIALIZER_MACROS_SVH

// clocked property, held off while reset is asserted
`define RCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, but also checked during reset
`define RCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/rcs_pkg.sv
package rcs_pkg;

  localparam int unsigned StepW = 5;
  typedef logic [StepW-1:0] step_t;

  localparam logic [23:0] Mask24    = 24'hFFFFFF;
  localparam logic [23:0] TsMarker  = 24'hFFFFFF;
  localparam logic [23:0] ChunkRst  = 24'd128;
  localparam logic [15:0] CsidOne   = 16'd63;
  localparam logic [15:0] CsidTwo   = 16'd319;
  localparam logic [15:0] CsidBias  = 16'd64;
  localparam logic [1:0]  FmtCont   = 2'd3;

  // byte source for one step
  typedef enum logic [4:0] {
    SEL_BH0, SEL_BH1, SEL_BH2,
    SEL_TS2, SEL_TS1, SEL_TS0,
    SEL_LEN2, SEL_LEN1, SEL_LEN0, SEL_TYPE,
    SEL_SID0, SEL_SID1, SEL_SID2, SEL_SID3,
    SEL_EXT3, SEL_EXT2, SEL_EXT1, SEL_EXT0,
    SEL_BODY
  } sel_e;

  // step condition; when false the sequencer jumps to the skip target
  typedef enum logic [2:0] {
    C_ALWAYS, C_NEVER, C_CSID64, C_CSID320, C_NOT_F3, C_FMT01, C_FMT0, C_EXT
  } cond_e;

  typedef struct packed {
    sel_e  sel;
    cond_e cond;
    step_t nxt;
    step_t skip;
  } ucw_t;

  typedef struct packed {
    logic csid64;
    logic csid320;
    logic not_f3;
    logic fmt01;
    logic fmt0;
    logic ext;
  } cond_t;

  typedef struct packed {
    logic  go;
    step_t entry;
  } launch_t;

  typedef struct packed {
    logic  idle;
    logic  emit;
    sel_e  sel;
    step_t step;
  } seq_out_t;

  localparam step_t ST_BH0   = 5'd0;
  localparam step_t ST_BH1   = 5'd1;
  localparam step_t ST_BH2   = 5'd2;
  localparam step_t ST_TS2   = 5'd3;
  localparam step_t ST_TS0   = 5'd5;
  localparam step_t ST_LEN2  = 5'd6;
  localparam step_t ST_TYPE  = 5'd9;
  localparam step_t ST_SID0  = 5'd10;
  localparam step_t ST_SID3  = 5'd13;
  localparam step_t ST_EXT3  = 5'd14;
  localparam step_t ST_EXT0  = 5'd17;
  localparam step_t ST_CBH0  = 5'd18;
  localparam step_t ST_CBH1  = 5'd19;
  localparam step_t ST_CBH2  = 5'd20;
  localparam step_t ST_BODY  = 5'd21;
  localparam step_t ST_IDLE  = 5'd22;

  function automatic ucw_t ucode(input step_t pc);
    ucw_t w;
    w = '{sel: SEL_BH0, cond: C_NEVER, nxt: ST_IDLE, skip: ST_IDLE};
    unique case (pc)
      5'd0:  w = '{SEL_BH0,  C_ALWAYS,  5'd1,    5'd1};
      5'd1:  w = '{SEL_BH1,  C_CSID64,  5'd2,    ST_TS2};
      5'd2:  w = '{SEL_BH2,  C_CSID320, ST_TS2,  ST_TS2};
      5'd3:  w = '{SEL_TS2,  C_NOT_F3,  5'd4,    ST_EXT3};
      5'd4:  w = '{SEL_TS1,  C_ALWAYS,  5'd5,    5'd5};
      5'd5:  w = '{SEL_TS0,  C_ALWAYS,  5'd6,    5'd6};
      5'd6:  w = '{SEL_LEN2, C_FMT01,   5'd7,    ST_EXT3};
      5'd7:  w = '{SEL_LEN1, C_ALWAYS,  5'd8,    5'd8};
      5'd8:  w = '{SEL_LEN0, C_ALWAYS,  5'd9,    5'd9};
      5'd9:  w = '{SEL_TYPE, C_ALWAYS,  5'd10,   5'd10};
      5'd10: w = '{SEL_SID0, C_FMT0,    5'd11,   ST_EXT3};
      5'd11: w = '{SEL_SID1, C_ALWAYS,  5'd12,   5'd12};
      5'd12: w = '{SEL_SID2, C_ALWAYS,  5'd13,   5'd13};
      5'd13: w = '{SEL_SID3, C_ALWAYS,  5'd14,   5'd14};
      5'd14: w = '{SEL_EXT3, C_EXT,     5'd15,   ST_IDLE};
      5'd15: w = '{SEL_EXT2, C_ALWAYS,  5'd16,   5'd16};
      5'd16: w = '{SEL_EXT1, C_ALWAYS,  5'd17,   5'd17};
      5'd17: w = '{SEL_EXT0, C_ALWAYS,  ST_IDLE, ST_IDLE};
      // continuation header, format 3, then the body byte
      5'd18: w = '{SEL_BH0,  C_ALWAYS,  ST_CBH1, ST_CBH1};
      5'd19: w = '{SEL_BH1,  C_CSID64,  ST_CBH2, ST_BODY};
      5'd20: w = '{SEL_BH2,  C_CSID320, ST_BODY, ST_BODY};
      5'd21: w = '{SEL_BODY, C_ALWAYS,  ST_IDLE, ST_IDLE};
      default: w = '{SEL_BH0, C_NEVER, ST_IDLE, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rcs_seq.sv
module rcs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcs_pkg::launch_t   launch_i,
  input  rcs_pkg::cond_t     cond_i,
  input  logic               slot_free_i,
  output rcs_pkg::seq_out_t  seq_o
);
  import rcs_pkg::*;

  step_t pc_q, pc_d;
  ucw_t  w;
  logic  idle;
  logic  taken;

  assign w    = ucode(pc_q);
  assign idle = (pc_q == ST_IDLE);

  always_comb begin
    unique case (w.cond)
      C_ALWAYS:  taken = 1'b1;
      C_NEVER:   taken = 1'b0;
      C_CSID64:  taken = cond_i.csid64;
      C_CSID320: taken = cond_i.csid320;
      C_NOT_F3:  taken = cond_i.not_f3;
      C_FMT01:   taken = cond_i.fmt01;
      C_FMT0:    taken = cond_i.fmt0;
      C_EXT:     taken = cond_i.ext;
      default:   taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (idle) begin
      if (launch_i.go) pc_d = launch_i.entry;
    end else if (!taken) begin
      pc_d = w.skip;
    end else if (slot_free_i) begin
      pc_d = w.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign seq_o.idle = idle;
  assign seq_o.emit = !idle && taken && slot_free_i;
  assign seq_o.sel  = w.sel;
  assign seq_o.step = pc_q;

endmodule

>>> hw/rtl/rtmp_chunk_serializer.sv
// start item: 1 to 18 header bytes, one per taken step; skipped field groups give no byte;
// first byte through the step and output registers; next item taken once the last is out
// body byte: through the step and output registers; next body byte taken once the sequencer
// idles again, after any continuation basic header goes in first (microcode step counter)
// reset: sequencer idle, no message open, chunk_size back to 128; no clearing pass
module rtmp_chunk_serializer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // header_format, csid, message_type_id, stream_id, timestamp,
  // length, body_byte, zero pad
  input  logic [127:0] s_axis_tdata_i,
  // req_type
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_byte
  output logic [7:0]   m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);
  import rcs_pkg::*;

  // input fields
  logic [1:0]  in_fmt;
  logic [15:0] in_csid;
  logic [7:0]  in_mtype;
  logic [31:0] in_sid;
  logic [31:0] in_ts;
  logic [23:0] in_len;
  logic [7:0]  in_body;

  assign in_fmt   = s_axis_tdata_i[1:0];
  assign in_csid  = s_axis_tdata_i[17:2];
  assign in_mtype = s_axis_tdata_i[25:18];
  assign in_sid   = s_axis_tdata_i[57:26];
  assign in_ts    = s_axis_tdata_i[89:58];
  assign in_len   = s_axis_tdata_i[113:90];
  assign in_body  = s_axis_tdata_i[121:114];

  // message payload
  logic [1:0]  fmt_q;
  logic [15:0] csid_q;
  logic [7:0]  mtype_q;
  logic [31:0] sid_q;
  logic [31:0] ts_q;
  logic [23:0] len_q;
  logic [7:0]  body_q;
  step_t       end_step_q;
  logic        hdr_end_q;
  logic        last_body_q;

  // control state
  logic        in_msg_q, in_msg_d;
  logic [23:0] rem_q, rem_d;
  logic [23:0] fill_q, fill_d;
  logic [23:0] chunk_size_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        in_xfer, start_xfer, body_xfer;
  logic        need_cont;
  logic        cfg_wr;
  logic        slot_free;
  logic        in_ext;
  step_t       in_end_step;
  launch_t     launch;
  cond_t       cond;
  seq_out_t    seq;
  logic [15:0] csid_adj;
  logic [23:0] ts24;
  logic [7:0]  bh_hi;
  logic [7:0]  byte_d;
  logic        last_d;

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign start_xfer = in_xfer && !s_axis_tuser_i;
  assign body_xfer  = in_xfer && s_axis_tuser_i && in_msg_q;
  assign need_cont  = (chunk_size_q != '0) && (fill_q >= chunk_size_q);

  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o && !paddr_i[2];
  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? 32'd0 : {8'd0, chunk_size_q};

  assign in_ext = |in_ts[31:24];

  // index of the last header step for this start item
  always_comb begin
    priority if (in_ext)          in_end_step = ST_EXT0;
    else if (in_fmt == 2'd0)      in_end_step = ST_SID3;
    else if (in_fmt == 2'd1)      in_end_step = ST_TYPE;
    else if (in_fmt == 2'd2)      in_end_step = ST_TS0;
    else if (in_csid > CsidTwo)   in_end_step = ST_BH2;
    else if (in_csid > CsidOne)   in_end_step = ST_BH1;
    else                          in_end_step = ST_BH0;
  end

  assign launch.go    = start_xfer || body_xfer;
  assign launch.entry = start_xfer ? ST_BH0 : (need_cont ? ST_CBH0 : ST_BODY);

  assign cond.csid64  = csid_q > CsidOne;
  assign cond.csid320 = csid_q > CsidTwo;
  assign cond.not_f3  = fmt_q != FmtCont;
  assign cond.fmt01   = !fmt_q[1];
  assign cond.fmt0    = fmt_q == 2'd0;
  assign cond.ext     = |ts_q[31:24];

  assign slot_free = !out_valid_q || m_axis_tready_i;

  rcs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .launch_i    (launch),
    .cond_i      (cond),
    .slot_free_i (slot_free),
    .seq_o       (seq)
  );

  assign s_axis_tready_o = seq.idle;

  assign csid_adj = csid_q - CsidBias;
  assign ts24     = cond.ext ? TsMarker : ts_q[23:0];
  assign bh_hi    = {fmt_q, 6'd0};

  always_comb begin
    unique case (seq.sel)
      SEL_BH0: begin
        if (!cond.csid64)       byte_d = bh_hi | {2'd0, csid_q[5:0]};
        else if (!cond.csid320) byte_d = bh_hi;
        else                    byte_d = bh_hi | 8'h01;
      end
      SEL_BH1:  byte_d = cond.csid320 ? csid_adj[15:8] : csid_adj[7:0];
      SEL_BH2:  byte_d = csid_adj[7:0];
      SEL_TS2:  byte_d = ts24[23:16];
      SEL_TS1:  byte_d = ts24[15:8];
      SEL_TS0:  byte_d = ts24[7:0];
      SEL_LEN2: byte_d = len_q[23:16];
      SEL_LEN1: byte_d = len_q[15:8];
      SEL_LEN0: byte_d = len_q[7:0];
      SEL_TYPE: byte_d = mtype_q;
      SEL_SID0: byte_d = sid_q[7:0];
      SEL_SID1: byte_d = sid_q[15:8];
      SEL_SID2: byte_d = sid_q[23:16];
      SEL_SID3: byte_d = sid_q[31:24];
      SEL_EXT3: byte_d = ts_q[31:24];
      SEL_EXT2: byte_d = ts_q[23:16];
      SEL_EXT1: byte_d = ts_q[15:8];
      SEL_EXT0: byte_d = ts_q[7:0];
      SEL_BODY: byte_d = body_q;
      default:  byte_d = '0;
    endcase
  end

  assign last_d = (seq.sel == SEL_BODY) ? last_body_q
                                        : (hdr_end_q && (seq.step == end_step_q));

  always_comb begin
    in_msg_d = in_msg_q;
    rem_d    = rem_q;
    fill_d   = fill_q;
    if (start_xfer) begin
      in_msg_d = (in_len != '0);
      rem_d    = in_len;
      fill_d   = '0;
    end else if (body_xfer) begin
      rem_d    = rem_q - 24'd1;
      in_msg_d = (rem_q != 24'd1);
      if (need_cont)            fill_d = 24'd1;
      else if (fill_q != Mask24) fill_d = fill_q + 24'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq.emit)             out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q     <= 1'b0;
      rem_q        <= '0;
      fill_q       <= '0;
      chunk_size_q <= ChunkRst;
      out_valid_q  <= 1'b0;
    end else begin
      in_msg_q    <= in_msg_d;
      rem_q       <= rem_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) chunk_size_q <= pwdata_i[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_xfer) begin
      fmt_q      <= in_fmt;
      csid_q     <= in_csid;
      mtype_q    <= in_mtype;
      sid_q      <= in_sid;
      ts_q       <= in_ts;
      len_q      <= in_len;
      end_step_q <= in_end_step;
      hdr_end_q  <= (in_len == '0);
    end else if (body_xfer) begin
      // continuation chunks carry format 3
      fmt_q       <= FmtCont;
      body_q      <= in_body;
      last_body_q <= (rem_q == 24'd1);
    end
    if (seq.emit) begin
      out_byte_q <= byte_d;
      out_last_q <= last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> hw/rtl/rcs_chk.sv
`include "rtmp_chunk_serializer_macros.svh"

module rcs_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [7:0]   m_axis_tdata_o,
  input logic         m_axis_tlast_o,
  input logic         psel_i,
  input logic         penable_i,
  input logic         pwrite_i,
  input logic [2:0]   paddr_i,
  input logic [31:0]  pwdata_i,
  input logic [31:0]  prdata_o,
  input logic         pready_o
);

  // a stalled output transfer keeps its byte and end mark
  `RCS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output changed while stalled")

  // a start transfer always produces header bytes, so input closes
  `RCS_ASSERT(a_start_busy, s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=> !s_axis_tready_o, "ready after start transfer")

  // a register write reads back on the next cycle
  `RCS_ASSERT(a_cfg_readback, psel_i && penable_i && pwrite_i && pready_o && !paddr_i[2] |=> paddr_i[2] || (prdata_o[23:0] == $past(pwdata_i[23:0])), "chunk size readback mismatch")

  `RCS_ASSERT_ALWAYS(a_prdata_hi, prdata_o[31:24] == 8'd0, "unused read bits set")

endmodule

bind rtmp_chunk_serializer rcs_chk u_rcs_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .psel_i          (psel_i),
  .penable_i       (penable_i),
  .pwrite_i        (pwrite_i),
  .paddr_i         (paddr_i),
  .pwdata_i        (pwdata_i),
  .prdata_o        (prdata_o),
  .pready_o        (pready_o)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcs_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned ShownErrors = 10;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems = 15;

  localparam logic [2:0] ADDR_CHUNK_SIZE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef enum logic {REQ_START, REQ_BODY} req_e;
  typedef enum logic [1:0] {FMT_FULL, FMT_NO_SID, FMT_TS_ONLY, FMT_CONT} fmt_e;

  // packed from the msb down, so fmt lands in the lowest bits of tdata
  typedef struct packed {
    logic [7:0]  body;
    logic [23:0] len;
    logic [31:0] ts;
    logic [31:0] sid;
    logic [7:0]  mtype;
    logic [15:0] csid;
    logic [1:0]  fmt;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } chunk_byte_t;

  typedef struct {
    req_e        req;
    item_t       f;
    int          typed_n;
    logic [63:0] typed_w;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_ready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;

  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [7:0]   m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic [31:0]  prdata_o;
  logic         pready_o;

  rtmp_chunk_serializer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // serializer state as the checker sees it
  logic [23:0] cfg_chunk = ChunkRst;
  logic        open_msg = 1'b0;
  logic [15:0] cur_csid = '0;
  logic [23:0] remain = '0;
  logic [23:0] fill = '0;

  chunk_byte_t step_out[$];
  chunk_byte_t pending_bytes_q[$];
  row_t        directed_rows[$];

  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned items_in = 0;
  int unsigned msgs_started = 0;
  int unsigned bytes_checked = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  function automatic void add_out(input logic [7:0] b);
    step_out.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void mark_last();
    chunk_byte_t t;
    t = step_out.pop_back();
    t.last = 1'b1;
    step_out.push_back(t);
  endfunction

  function automatic void add_basic(input logic [1:0] fmt, input logic [15:0] csid);
    logic [15:0] v;
    v = csid - CsidBias;
    if (csid <= CsidOne) begin
      add_out({fmt, csid[5:0]});
    end else if (csid <= CsidTwo) begin
      add_out({fmt, 6'd0});
      add_out(v[7:0]);
    end else begin
      add_out({fmt, 6'd1});
      add_out(v[15:8]);
      add_out(v[7:0]);
    end
  endfunction

  // bytes one accepted item puts on the chunk stream, and the state it leaves
  function automatic void serialize_item(input req_e req, input item_t f);
    logic        ext;
    logic [23:0] ts24;
    step_out.delete();
    if (req == REQ_START) begin
      ext = f.ts > {8'd0, TsMarker};
      ts24 = ext ? TsMarker : f.ts[23:0];
      add_basic(f.fmt, f.csid);
      if (f.fmt != FMT_CONT) begin
        add_out(ts24[23:16]);
        add_out(ts24[15:8]);
        add_out(ts24[7:0]);
      end
      if (f.fmt == FMT_FULL || f.fmt == FMT_NO_SID) begin
        add_out(f.len[23:16]);
        add_out(f.len[15:8]);
        add_out(f.len[7:0]);
        add_out(f.mtype);
      end
      if (f.fmt == FMT_FULL) begin
        add_out(f.sid[7:0]);
        add_out(f.sid[15:8]);
        add_out(f.sid[23:16]);
        add_out(f.sid[31:24]);
      end
      if (ext) begin
        add_out(f.ts[31:24]);
        add_out(f.ts[23:16]);
        add_out(f.ts[15:8]);
        add_out(f.ts[7:0]);
      end
      cur_csid = f.csid;
      remain = f.len;
      fill = '0;
      open_msg = (f.len != '0);
      if (f.len == '0) mark_last();
    end else if (open_msg) begin
      if (cfg_chunk != '0 && fill >= cfg_chunk) begin
        add_basic(FMT_CONT, cur_csid);
        fill = '0;
      end
      add_out(f.body);
      if (fill != Mask24) fill = fill + 24'd1;
      if (remain != '0) remain = remain - 24'd1;
      if (remain == '0) begin
        open_msg = 1'b0;
        mark_last();
      end
    end
  endfunction

  function automatic item_t rand_fields();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[121:0];
  endfunction

  function automatic logic [15:0] rand_csid();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 63));
      1: return 16'($urandom_range(64, 319));
      2: return 16'($urandom_range(320, 65535));
      3: begin
        case ($urandom_range(0, 4))
          0: return 16'd63;
          1: return 16'd64;
          2: return 16'd319;
          3: return 16'd320;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // input side: optional gap, then hold the item until the transfer
  task automatic send_item(input req_e req, input item_t f, input int typed_n,
                           input logic [63:0] typed_w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {6'd0, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (req == REQ_START || open_msg) items_in++;
    if (req == REQ_START) msgs_started++;
    serialize_item(req, f);
    if (typed_n < 0) begin
      foreach (step_out[k]) pending_bytes_q.push_back(step_out[k]);
    end else begin
      for (int k = 0; k < typed_n; k++) begin
        pending_bytes_q.push_back('{data: typed_w[63 - 8 * k -: 8], last: k == typed_n - 1});
      end
    end
  endtask

  task automatic send_body(input logic [7:0] b);
    item_t f;
    f = rand_fields();
    f.body = b;
    send_item(REQ_BODY, f, -1, '0);
  endtask

  task automatic send_message(input logic [23:0] len, input int body_n);
    item_t f;
    f = rand_fields();
    f.csid = rand_csid();
    if ($urandom_range(0, 1) == 0) f.ts = {8'd0, f.ts[23:0]};
    f.len = len;
    send_item(REQ_START, f, -1, '0);
    repeat (body_n) send_body(8'($urandom));
  endtask

  task automatic wait_drained(input int unsigned settle);
    s_tvalid <= 1'b0;
    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // setup then access; psel stays up so another access may follow at once
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_chunk_reg();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_CHUNK_SIZE, '0, rd);
    if (rd != {8'd0, cfg_chunk}) begin
      if (errors < ShownErrors) begin
        $display("chunk_size readback: expected %06h, got %08h", cfg_chunk, rd);
      end
      errors++;
    end
  endtask

  task automatic set_chunk_size(input logic [23:0] size);
    logic [31:0] wdata;
    logic [31:0] rd;
    wdata = $urandom;
    wdata[23:0] = size;
    apb_access(1'b1, ADDR_CHUNK_SIZE, wdata, rd);
    cfg_chunk = size;
    settings_used++;
    check_chunk_reg();
  endtask

  task automatic add_row(input req_e req, input logic [1:0] fmt, input logic [15:0] csid,
                         input logic [7:0] mtype, input logic [31:0] sid,
                         input logic [31:0] ts, input logic [23:0] len, input logic [7:0] body,
                         input int typed_n, input logic [63:0] typed_w);
    row_t r;
    r.req = req;
    r.f = '{body: body, len: len, ts: ts, sid: sid, mtype: mtype, csid: csid, fmt: fmt};
    r.typed_n = typed_n;
    r.typed_w = typed_w;
    directed_rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles,
               pending_bytes_q.size());
      $display("** rtmp_chunk_serializer: FAILED **");
      $finish;
    end
  end

  // output side stalls in short bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : out_check
    chunk_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      bytes_checked++;
      if (pending_bytes_q.size() == 0) begin
        if (errors < ShownErrors) begin
          $display("unexpected output transfer: byte %02h last %0b",
                   m_axis_tdata_o, m_axis_tlast_o);
        end
        errors++;
      end else begin
        want = pending_bytes_q.pop_front();
        if (m_axis_tdata_o !== want.data || m_axis_tlast_o !== want.last) begin
          if (errors < ShownErrors) begin
            $display("output transfer %0d: expected byte %02h last %0b, got %02h last %0b",
                     bytes_checked, want.data, want.last, m_axis_tdata_o, m_axis_tlast_o);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    logic [23:0] sizes[8];
    logic [31:0] rd;
    int unsigned phase_base;
    int unsigned pick;
    int          cut;
    logic [23:0] len;
    int          carry;

    sizes = '{24'd1, 24'd0, 24'hFFFFFF, 24'd2, 24'd3, 24'd128, 24'd0, 24'd7};
    carry = 0;

    // body while idle, basic header forms, field extremes, abandoned message
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h5A, 0, '0);
    add_row(REQ_START, FMT_CONT, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h00, 1, 64'hC0 << 56);
    add_row(REQ_START, FMT_CONT, 16'd63, 8'h00, 32'h0, 32'h0, 24'd0, 8'h00, 1, 64'hFF << 56);
    add_row(REQ_START, FMT_TS_ONLY, 16'd64, 8'h00, 32'h0, 32'h00FFFFFF, 24'd0, 8'h00,
            5, 64'h80_00_FF_FF_FF << 24);
    add_row(REQ_START, FMT_TS_ONLY, 16'd319, 8'h00, 32'h0, 32'h0, 24'd0, 8'h00,
            5, 64'h80_FF_00_00_00 << 24);
    add_row(REQ_START, FMT_TS_ONLY, 16'd320, 8'h00, 32'h0, 32'h1, 24'd0, 8'h00,
            6, 64'h81_01_00_00_00_01 << 16);
    add_row(REQ_START, FMT_CONT, 16'hFFFF, 8'h00, 32'h0, 32'h0, 24'd0, 8'h00,
            3, 64'hC1_FF_BF << 40);
    add_row(REQ_START, FMT_FULL, 16'd0, 8'hFF, 32'hFFFFFFFF, 32'h00FFFFFF, 24'd0, 8'h00,
            -1, '0);
    add_row(REQ_START, FMT_NO_SID, 16'd1, 8'h00, 32'h0, 32'h01000000, 24'd0, 8'h00, -1, '0);
    add_row(REQ_START, FMT_FULL, 16'hFFFF, 8'h14, 32'h04030201, 32'hFFFFFFFF, 24'd3, 8'h00,
            -1, '0);
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h00, -1, '0);
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'hFF, -1, '0);
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'hA5, -1, '0);
    // past the declared length
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h3C, 0, '0);
    add_row(REQ_START, FMT_NO_SID, 16'd300, 8'h09, 32'h0, 32'h00123456, 24'hFFFFFF, 8'h00,
            -1, '0);
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h11, -1, '0);
    // new start while the long message is still open
    add_row(REQ_START, FMT_CONT, 16'd2, 8'h00, 32'h0, 32'h89ABCDEF, 24'd2, 8'h00, -1, '0);
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h80, -1, '0);
    add_row(REQ_BODY, FMT_FULL, 16'd0, 8'h00, 32'h0, 32'h0, 24'd0, 8'h7F, -1, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_chunk_reg();
    apb_release();

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].req, directed_rows[i].f, directed_rows[i].typed_n,
                directed_rows[i].typed_w);
    end
    wait_drained(SettleCycles);

    foreach (sizes[p]) begin
      if (p == 6) sizes[p] = 24'($urandom_range(1, 16));
      if (p == 7) calm = 1'b1;
      set_chunk_size(sizes[p]);
      if (p == 3) begin
        // a write to an unmapped address must leave chunk_size alone
        apb_access(1'b1, ADDR_UNUSED, $urandom, rd);
        check_chunk_reg();
      end
      apb_release();

      // finish the message left open before the write, under the new size
      repeat (carry) send_body(8'($urandom));
      carry = 0;

      phase_base = items_in;
      while (items_in - phase_base < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          len = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(21, 48))
                                            : 24'($urandom_range(0, 20));
          send_message(len, int'(len));
        end else if (pick < 88) begin
          // broken message, abandoned by the next start
          len = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(21, 24'hFFFFFF))
                                            : 24'($urandom_range(1, 30));
          cut = (len > 24'd20) ? $urandom_range(0, 20) : $urandom_range(0, int'(len) - 1);
          send_message(len, cut);
        end else if (pick < 96) begin
          send_body(8'($urandom));
        end else begin
          wait_drained(0);
        end
      end

      if (p != 7) begin
        send_message(24'd12, 7);
        carry = 5;
      end
      wait_drained(SettleCycles);
    end

    $display("covered %0d input transfers in %0d messages over %0d chunk_size settings",
             items_in, msgs_started, settings_used);
    $display("compared %0d output transfers, %0d mismatches", bytes_checked, errors);
    if (errors == 0) begin
      $display("** rtmp_chunk_serializer: PASSED **");
    end else begin
      $display("** rtmp_chunk_serializer: FAILED **");
    end
    $finish;
  end

endmodule
